/* src/dtp_pkg.sv */
// Shared widths, constants, types and tables of the duration text parser.
package dtp_pkg;

  localparam int unsigned SecW    = 32;
  localparam int unsigned UsecW   = 20;
  localparam int unsigned ScaleW  = 17;  // widest unit factor is 86400
  localparam int unsigned MulAW   = 32;
  localparam int unsigned MulBW   = 20;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned DivW    = 37;  // microseconds times the widest unit factor
  localparam int unsigned RecipW  = 32;

  // one million is 2^6 * 15625: shift out the power of two, then multiply by
  // ceil(2^45 / 15625); exact for every dividend below 2^37
  localparam int unsigned         UsecShift  = 6;
  localparam int unsigned         RecipShift = 45;
  localparam logic [RecipW-1:0]   UsecRecip  = 32'd2251799814;

  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;
  localparam logic [3:0]       UsecDigits = 4'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // 10^n for n in 0..6
  function automatic logic [MulBW-1:0] pow10(input logic [2:0] n);
    logic [MulBW-1:0] v;
    case (n)
      3'd0:    v = 20'd1;
      3'd1:    v = 20'd10;
      3'd2:    v = 20'd100;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd10000;
      3'd5:    v = 20'd100000;
      3'd6:    v = 20'd1000000;
      default: v = 20'd1000000;
    endcase
    return v;
  endfunction

  // seconds per unit: s, m, h, d
  function automatic logic [ScaleW-1:0] unit_scale(input logic [1:0] u);
    logic [ScaleW-1:0] v;
    case (u)
      2'd0:    v = 17'd1;
      2'd1:    v = 17'd60;
      2'd2:    v = 17'd3600;
      2'd3:    v = 17'd86400;
      default: v = 17'd1;
    endcase
    return v;
  endfunction

endpackage

/* src/duration_text_parser.sv */
// Top level of the duration text parser: character scanner and conversion sequencer.
//
// Input channel: one character per transfer on ch_i, with new_command_i; a
// zero character ends the argument. new_command_i high clears the running
// totals when its transfer is taken. Output channel: one result per
// terminator with status, the argument's seconds and microseconds and the
// running totals after carry.
// A non-zero character updates the scanner state; the block takes characters back
// to back while in_stall_o is low. A terminator that ends an error or an empty
// argument moves to S_FIN, raising in_stall_o for one cycle when the output slot
// is free, and S_FIN registers its result into the output slot. A valid number
// goes through a sequencer around one shared 32x20 multiplier and a two-step
// reciprocal divide by one million through S_SCALE, S_USMUL, S_DIVU, S_WMUL,
// S_ARG and S_FIN, holding in_stall_o high, alike for every fraction length and unit.
// A result waits in the output registers while out_stall_i is high; new
// characters are still taken meanwhile, and the next result holds in_stall_o
// high until the output slot drains.
// Reset clears the totals and the per-argument state, and drops any result.
module duration_text_parser #(
  parameter int unsigned MAX_FRAC_DIGITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 ch_i,
  input  logic                       new_command_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [dtp_pkg::SecW-1:0]   arg_seconds_o,
  output logic [dtp_pkg::UsecW-1:0]  arg_microseconds_o,
  output logic [dtp_pkg::SecW-1:0]   sum_seconds_o,
  output logic [dtp_pkg::UsecW-1:0]  sum_microseconds_o
);

  localparam logic [3:0] MaxFracDigits = 4'(MAX_FRAC_DIGITS);

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StBadIntv = 2'd2;
  localparam logic [1:0] StBadSufx = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSec   = 8'h73;
  localparam logic [7:0] ChMin   = 8'h6D;
  localparam logic [7:0] ChHour  = 8'h68;
  localparam logic [7:0] ChDay   = 8'h64;

  typedef enum logic [2:0] {
    PH_SKIP, PH_INT, PH_FRAC, PH_SUFFIX, PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_USMUL, S_DIVU, S_WMUL, S_ARG, S_FIN
  } seq_e;

  seq_e   state_q;
  phase_e phase_q, phase_d;
  logic [dtp_pkg::SecW-1:0]  whole_q, whole_d;
  logic [dtp_pkg::UsecW-1:0] frac_q, frac_d;
  logic [3:0]                fdig_q, fdig_d;
  logic [1:0]                unit_q, unit_d;
  logic [1:0]                perr_q, perr_d;
  logic [1:0]                status_q;
  logic [dtp_pkg::SecW-1:0]  tot_s_q;
  logic [dtp_pkg::UsecW-1:0] tot_us_q;
  logic [dtp_pkg::UsecW-1:0] frac_us_q;
  logic [dtp_pkg::UsecW-1:0] arg_us_q;
  logic [dtp_pkg::SecW-1:0]  arg_s_q;
  logic [dtp_pkg::ScaleW-1:0] qsec_q;

  logic                      out_valid_q;
  logic [1:0]                out_status_q;
  logic [dtp_pkg::SecW-1:0]  out_arg_s_q, out_sum_s_q;
  logic [dtp_pkg::UsecW-1:0] out_arg_us_q, out_sum_us_q;

  logic       in_xfer, is_dig, is_dot, is_blank, is_sfx;
  logic [3:0] digit;
  logic [1:0] sfx_code;

  logic [dtp_pkg::MulAW-1:0] mul_a;
  logic [dtp_pkg::MulBW-1:0] mul_b;
  logic [dtp_pkg::ProdW-1:0] prod;
  logic [dtp_pkg::ScaleW-1:0] scale;
  logic [3:0]                 fdig_lo;

  logic                        div_start;
  logic [dtp_pkg::DivW-1:0]    div_dividend;
  logic [dtp_pkg::ScaleW-1:0]  div_quo;
  logic [dtp_pkg::UsecW-1:0]   div_rem;
  dtp_pkg::div_sts_t           div_sts;

  logic                      slot_free;
  logic                      fin_fire;
  logic [dtp_pkg::UsecW:0]   us_sum;
  logic                      us_carry;
  logic [dtp_pkg::UsecW-1:0] new_tot_us;
  logic [dtp_pkg::SecW-1:0]  new_tot_s;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign fin_fire   = (state_q == S_FIN) && slot_free;

  // character classes
  always_comb begin
    is_dig   = (ch_i >= ChZero) && (ch_i <= ChNine);
    is_dot   = (ch_i == ChDot);
    is_blank = (ch_i == ChSpace) || (ch_i == ChTab);
    digit    = 4'(ch_i - ChZero);
    is_sfx   = 1'b1;
    case (ch_i)
      ChSec:   sfx_code = 2'd0;
      ChMin:   sfx_code = 2'd1;
      ChHour:  sfx_code = 2'd2;
      ChDay:   sfx_code = 2'd3;
      default: begin
        sfx_code = 2'd0;
        is_sfx   = 1'b0;
      end
    endcase
  end

  // scanner step for one non-zero character
  always_comb begin
    phase_d = phase_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    fdig_d  = fdig_q;
    unit_d  = unit_q;
    perr_d  = perr_q;
    case (phase_q)
      PH_INT: begin
        if (is_dig) begin
          whole_d = (whole_q << 3) + (whole_q << 1) + dtp_pkg::SecW'(digit);
        end else if (is_dot) begin
          phase_d = PH_FRAC;
        end else if (is_sfx) begin
          unit_d  = sfx_code;
          phase_d = PH_SUFFIX;
        end else begin
          perr_d  = StBadSufx;
          phase_d = PH_ERROR;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (fdig_q < MaxFracDigits) begin
            // digits past the sixth fall below a microsecond: count them only, up to MAX_FRAC_DIGITS
            if (fdig_q < dtp_pkg::UsecDigits) begin
              frac_d = (frac_q << 3) + (frac_q << 1) + dtp_pkg::UsecW'(digit);
            end
            fdig_d = fdig_q + 4'd1;
          end
        end else if (is_sfx) begin
          unit_d  = sfx_code;
          phase_d = PH_SUFFIX;
        end else begin
          perr_d  = StBadSufx;
          phase_d = PH_ERROR;
        end
      end
      PH_SUFFIX: begin
        perr_d  = StBadIntv;
        phase_d = PH_ERROR;
      end
      PH_ERROR: begin
      end
      default: begin
        phase_d = PH_SKIP;
        if (is_blank) begin
        end else if (is_dig) begin
          whole_d = dtp_pkg::SecW'(digit);
          phase_d = PH_INT;
        end else if (is_dot) begin
          phase_d = PH_FRAC;
        end else begin
          perr_d  = StBadIntv;
          phase_d = PH_ERROR;
        end
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    scale   = dtp_pkg::unit_scale(unit_q);
    fdig_lo = (fdig_q < dtp_pkg::UsecDigits) ? (dtp_pkg::UsecDigits - fdig_q) : 4'd0;
    case (state_q)
      S_SCALE: begin
        mul_a = dtp_pkg::MulAW'(frac_q);
        mul_b = dtp_pkg::pow10(fdig_lo[2:0]);
      end
      S_USMUL: begin
        mul_a = dtp_pkg::MulAW'(frac_us_q);
        mul_b = dtp_pkg::MulBW'(scale);
      end
      S_WMUL: begin
        mul_a = whole_q;
        mul_b = dtp_pkg::MulBW'(scale);
      end
      default: begin
        mul_a = whole_q;
        mul_b = dtp_pkg::MulBW'(scale);
      end
    endcase
    prod = dtp_pkg::ProdW'(mul_a) * dtp_pkg::ProdW'(mul_b);
  end

  // split the scaled microseconds into seconds and remainder
  assign div_start    = (state_q == S_USMUL);
  assign div_dividend = prod[dtp_pkg::DivW-1:0];

  dtp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .sts_o       (div_sts)
  );

  // totals update with microsecond carry
  always_comb begin
    us_sum     = {1'b0, tot_us_q} + {1'b0, arg_us_q};
    us_carry   = us_sum >= {1'b0, dtp_pkg::UsecPerSec};
    new_tot_us = us_carry ? dtp_pkg::UsecW'(us_sum - {1'b0, dtp_pkg::UsecPerSec})
                          : us_sum[dtp_pkg::UsecW-1:0];
    new_tot_s  = tot_s_q + arg_s_q + dtp_pkg::SecW'(us_carry);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_SKIP;
      whole_q     <= '0;
      frac_q      <= '0;
      fdig_q      <= '0;
      unit_q      <= '0;
      perr_q      <= '0;
      tot_s_q     <= '0;
      tot_us_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (new_command_i) begin
              tot_s_q  <= '0;
              tot_us_q <= '0;
            end
            if (ch_i != 8'd0) begin
              phase_q <= phase_d;
              whole_q <= whole_d;
              frac_q  <= frac_d;
              fdig_q  <= fdig_d;
              unit_q  <= unit_d;
              perr_q  <= perr_d;
            end else if (phase_q == PH_ERROR) begin
              status_q <= perr_q;
              state_q  <= S_FIN;
            end else if (phase_q == PH_INT || phase_q == PH_FRAC ||
                         phase_q == PH_SUFFIX) begin
              status_q <= StOk;
              state_q  <= S_SCALE;
            end else begin
              status_q <= StMissing;
              state_q  <= S_FIN;
            end
          end
        end
        S_SCALE: begin
          frac_us_q <= prod[dtp_pkg::UsecW-1:0];
          state_q   <= S_USMUL;
        end
        S_USMUL: begin
          state_q <= S_DIVU;
        end
        S_DIVU: begin
          if (div_sts.done) begin
            arg_us_q <= div_rem;
            qsec_q   <= div_quo;
            state_q  <= S_WMUL;
          end
        end
        S_WMUL: begin
          arg_s_q <= prod[dtp_pkg::SecW-1:0];
          state_q <= S_ARG;
        end
        S_ARG: begin
          arg_s_q <= arg_s_q + dtp_pkg::SecW'(qsec_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          // hold until the output slot is free
          if (fin_fire) begin
            out_status_q <= status_q;
            if (status_q == StOk) begin
              out_arg_s_q  <= arg_s_q;
              out_arg_us_q <= arg_us_q;
              out_sum_s_q  <= new_tot_s;
              out_sum_us_q <= new_tot_us;
              tot_s_q      <= new_tot_s;
              tot_us_q     <= new_tot_us;
            end else begin
              out_arg_s_q  <= '0;
              out_arg_us_q <= '0;
              out_sum_s_q  <= tot_s_q;
              out_sum_us_q <= tot_us_q;
            end
            phase_q <= PH_SKIP;
            whole_q <= '0;
            frac_q  <= '0;
            fdig_q  <= '0;
            unit_q  <= '0;
            perr_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign arg_seconds_o      = out_arg_s_q;
  assign arg_microseconds_o = out_arg_us_q;
  assign sum_seconds_o      = out_sum_s_q;
  assign sum_microseconds_o = out_sum_us_q;

endmodule

/* src/dtp_div.sv */
// Divide by one million by reciprocal multiply: quotient, then remainder.
module dtp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dtp_pkg::DivW-1:0]     dividend_i,
  output logic [dtp_pkg::ScaleW-1:0]   quotient_o,
  output logic [dtp_pkg::UsecW-1:0]    remainder_o,
  output dtp_pkg::div_sts_t            sts_o
);

  logic [dtp_pkg::DivW-1:0]     num_q;
  logic [dtp_pkg::ScaleW-1:0]   quo_q;
  logic [dtp_pkg::UsecW-1:0]    rem_q;
  logic                         busy_q, step_q, done_q;
  logic [dtp_pkg::RecipW-1:0]   mul_a, mul_b;
  logic [2*dtp_pkg::RecipW-1:0] prod;
  logic [dtp_pkg::DivW-1:0]     back;

  // first step: quotient by reciprocal; second step: quotient times one million
  always_comb begin
    if (step_q) begin
      mul_a = dtp_pkg::RecipW'(quo_q);
      mul_b = dtp_pkg::RecipW'(dtp_pkg::UsecPerSec);
    end else begin
      mul_a = dtp_pkg::RecipW'(num_q[dtp_pkg::DivW-1:dtp_pkg::UsecShift]);
      mul_b = dtp_pkg::UsecRecip;
    end
    prod = (2*dtp_pkg::RecipW)'(mul_a) * (2*dtp_pkg::RecipW)'(mul_b);
    back = num_q - prod[dtp_pkg::DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 1'b0;
      end else if (busy_q) begin
        if (!step_q) begin
          step_q <= 1'b1;
        end else begin
          busy_q <= 1'b0;
          step_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end else if (busy_q && !step_q) begin
      quo_q <= prod[dtp_pkg::RecipShift+dtp_pkg::ScaleW-1:dtp_pkg::RecipShift];
    end else if (busy_q && step_q) begin
      rem_q <= back[dtp_pkg::UsecW-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;

endmodule
